[src/mqtt_at_receive_line_parser_core_assert.svh]
// assertion macros for the subscription line parser
`ifndef MQTT_AT_RECEIVE_LINE_PARSER_CORE_ASSERT_SVH
`define MQTT_AT_RECEIVE_LINE_PARSER_CORE_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define MQRX_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define MQRX_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

[src/mqrx_pkg.sv]
// shared constants and character tables for the subscription line parser
`default_nettype none
package mqrx_pkg;

   localparam int TopicMaxDefault   = 64;
   localparam int PayloadMaxDefault = 960;

   localparam logic [1:0] KIND_TOPIC   = 2'd0;
   localparam logic [1:0] KIND_PAYLOAD = 2'd1;
   localparam logic [1:0] KIND_STATUS  = 2'd2;

   localparam logic [1:0] CLASS_OTHER  = 2'd0;

   localparam logic [3:0] PREFIX_LEN = 4'd15;

   localparam logic [7:0] CHAR_QUOTE = 8'h22;
   localparam logic [7:0] CHAR_COMMA = 8'h2c;
   localparam logic [7:0] CHAR_NUL   = 8'h00;

   typedef struct packed {
      logic       valid;
      logic [1:0] kind;
      logic [7:0] char_out;
      logic       parse_ok;
      logic [1:0] topic_class;
   } result_type;

   // characters of the line prefix
   function automatic logic [7:0] lead_char(input logic [3:0] pos);
      logic [7:0] c;
      unique case (pos)
         4'd0:    c = "A";
         4'd1:    c = "T";
         4'd2:    c = "+";
         4'd3:    c = "M";
         4'd4:    c = "Q";
         4'd5:    c = "T";
         4'd6:    c = "T";
         4'd7:    c = "S";
         4'd8:    c = "U";
         4'd9:    c = "B";
         4'd10:   c = "R";
         4'd11:   c = "E";
         4'd12:   c = "C";
         4'd13:   c = "V";
         4'd14:   c = "=";
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   // length of each known topic
   function automatic logic [3:0] class_len(input logic [1:0] k);
      logic [3:0] n;
      unique case (k)
         2'd1:    n = 4'd13;
         default: n = 4'd10;
      endcase
      return n;
   endfunction

   // characters of the known topics: 0 ota, 1 config, 2 cmd
   function automatic logic [7:0] class_char(input logic [1:0] k, input logic [3:0] p);
      logic [7:0] c;
      c = 8'h00;
      unique case (p)
         4'd0: c = "d";
         4'd1: c = "e";
         4'd2: c = "v";
         4'd3: c = "i";
         4'd4: c = "c";
         4'd5: c = "e";
         4'd6: c = "/";
         4'd7: begin
            unique case (k)
               2'd0:    c = "o";
               default: c = "c";
            endcase
         end
         4'd8: begin
            unique case (k)
               2'd0:    c = "t";
               2'd1:    c = "o";
               default: c = "m";
            endcase
         end
         4'd9: begin
            unique case (k)
               2'd0:    c = "a";
               2'd1:    c = "n";
               default: c = "d";
            endcase
         end
         4'd10:   c = "f";
         4'd11:   c = "i";
         4'd12:   c = "g";
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage
`default_nettype wire

[src/mqtt_at_receive_line_parser_core.sv]
// subscription line parser: one character per request, topic/payload/status out
//
//  channel  direction  handshake             payload
//  req      in         req_valid/req_stall   req_char_in, req_end_of_line
//  rsp      out        rsp_valid/rsp_stall   rsp_kind, rsp_char_out, rsp_parse_ok,
//                                            rsp_topic_class
//
//  a request passes the input register, then the result register
//  one request per cycle sustained while the result is not stalled; the phase update is a single short pass
//  reset clears the phase, counters, match flags and both valid bits
//  a stalled result holds the result register; the input register keeps
//  accepting until it too is full
`default_nettype none
`include "mqtt_at_receive_line_parser_core_assert.svh"
module mqtt_at_receive_line_parser_core #(
   parameter int TOPIC_MAX   = mqrx_pkg::TopicMaxDefault,
   parameter int PAYLOAD_MAX = mqrx_pkg::PayloadMaxDefault
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_char_in,
   input  wire logic       req_end_of_line,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [1:0]      rsp_kind,
   output logic [7:0]      rsp_char_out,
   output logic            rsp_parse_ok,
   output logic [1:0]      rsp_topic_class
);

   localparam int TcW = $clog2(TOPIC_MAX);
   localparam int PcW = $clog2(PAYLOAD_MAX);

   localparam logic [3:0] PH_PREFIX = 4'd0;
   localparam logic [3:0] PH_COMMA1 = 4'd1;
   localparam logic [3:0] PH_TOPIC0 = 4'd2;
   localparam logic [3:0] PH_TOPIC  = 4'd3;
   localparam logic [3:0] PH_SKIP   = 4'd4;
   localparam logic [3:0] PH_COMMA2 = 4'd5;
   localparam logic [3:0] PH_PAY0   = 4'd6;
   localparam logic [3:0] PH_PAY    = 4'd7;
   localparam logic [3:0] PH_OK     = 4'd8;
   localparam logic [3:0] PH_FAIL   = 4'd9;

   logic           in_valid_ff;
   logic [7:0]     in_char_ff;
   logic           in_eol_ff;

   logic [3:0]     phase_ff, phase_in;
   logic [3:0]     prefix_pos_ff, prefix_pos_in;
   logic [TcW-1:0] topic_count_ff, topic_count_in;
   logic [PcW-1:0] payload_count_ff, payload_count_in;
   logic [2:0]     flags_ff, flags_in;

   logic           out_valid_ff;
   logic [1:0]     out_kind_ff;
   logic [7:0]     out_char_ff;
   logic           out_ok_ff;
   logic [1:0]     out_class_ff;

   logic                  proceed;
   mqrx_pkg::result_type  res;
   logic                  text_ok;
   logic [1:0]            fin_class;

   assign proceed   = !out_valid_ff || !rsp_stall;
   assign req_stall = in_valid_ff && !proceed;

   assign text_ok = (phase_ff == PH_PAY0) || (phase_ff == PH_OK);

   // class from the first known topic still matching at full length
   always_comb begin
      fin_class = mqrx_pkg::CLASS_OTHER;
      for (int k = 2; k >= 0; k--) begin
         if (flags_ff[k] && (topic_count_ff == TcW'(mqrx_pkg::class_len(2'(k))))) begin
            fin_class = 2'(k + 1);
         end
      end
   end

   always_comb begin
      phase_in         = phase_ff;
      prefix_pos_in    = prefix_pos_ff;
      topic_count_in   = topic_count_ff;
      payload_count_in = payload_count_ff;
      flags_in         = flags_ff;
      res              = '0;
      if (in_eol_ff) begin
         res.valid        = 1'b1;
         res.kind         = mqrx_pkg::KIND_STATUS;
         res.parse_ok     = text_ok;
         res.topic_class  = text_ok ? fin_class : mqrx_pkg::CLASS_OTHER;
         phase_in         = PH_PREFIX;
         prefix_pos_in    = '0;
         topic_count_in   = '0;
         payload_count_in = '0;
         flags_in         = 3'b111;
      end else if ((phase_ff == PH_OK) || (phase_ff == PH_FAIL)) begin
         phase_in = phase_ff;
      end else if (in_char_ff == mqrx_pkg::CHAR_NUL) begin
         phase_in = text_ok ? PH_OK : PH_FAIL;
      end else begin
         unique case (phase_ff)
            PH_PREFIX: begin
               if ((prefix_pos_ff < mqrx_pkg::PREFIX_LEN) &&
                   (in_char_ff == mqrx_pkg::lead_char(prefix_pos_ff))) begin
                  prefix_pos_in = prefix_pos_ff + 4'd1;
                  if (prefix_pos_in == mqrx_pkg::PREFIX_LEN) begin
                     phase_in = PH_COMMA1;
                  end
               end else begin
                  phase_in = PH_FAIL;
               end
            end
            PH_COMMA1: begin
               if (in_char_ff == mqrx_pkg::CHAR_COMMA) begin
                  phase_in = PH_TOPIC0;
               end
            end
            PH_TOPIC0: begin
               priority if (in_char_ff == mqrx_pkg::CHAR_QUOTE) begin
                  phase_in = PH_TOPIC;
               end else if (in_char_ff == mqrx_pkg::CHAR_COMMA) begin
                  phase_in = PH_PAY0;
               end else begin
                  phase_in = PH_COMMA2;
               end
            end
            PH_TOPIC: begin
               priority if (in_char_ff == mqrx_pkg::CHAR_QUOTE) begin
                  phase_in = PH_SKIP;
               end else if (topic_count_ff < TcW'(TOPIC_MAX - 1)) begin
                  for (int k = 0; k < 3; k++) begin
                     if ((topic_count_ff >= TcW'(mqrx_pkg::class_len(2'(k)))) ||
                         (in_char_ff != mqrx_pkg::class_char(2'(k), topic_count_ff[3:0]))) begin
                        flags_in[k] = 1'b0;
                     end
                  end
                  topic_count_in = topic_count_ff + TcW'(1);
                  res.valid      = 1'b1;
                  res.kind       = mqrx_pkg::KIND_TOPIC;
                  res.char_out   = in_char_ff;
               end else begin
                  phase_in = PH_TOPIC;
               end
            end
            PH_SKIP: begin
               phase_in = PH_COMMA2;
            end
            PH_COMMA2: begin
               if (in_char_ff == mqrx_pkg::CHAR_COMMA) begin
                  phase_in = PH_PAY0;
               end
            end
            PH_PAY0: begin
               phase_in = (in_char_ff == mqrx_pkg::CHAR_QUOTE) ? PH_PAY : PH_OK;
            end
            PH_PAY: begin
               priority if (in_char_ff == mqrx_pkg::CHAR_QUOTE) begin
                  phase_in = PH_OK;
               end else if (payload_count_ff < PcW'(PAYLOAD_MAX - 1)) begin
                  payload_count_in = payload_count_ff + PcW'(1);
                  res.valid        = 1'b1;
                  res.kind         = mqrx_pkg::KIND_PAYLOAD;
                  res.char_out     = in_char_ff;
               end else begin
                  phase_in = PH_PAY;
               end
            end
            default: begin
               phase_in = PH_FAIL;
            end
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
      if (req_valid && !req_stall) begin
         in_char_ff <= req_char_in;
         in_eol_ff  <= req_end_of_line;
      end
   end

   // line state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_PREFIX;
         prefix_pos_ff    <= '0;
         topic_count_ff   <= '0;
         payload_count_ff <= '0;
         flags_ff         <= 3'b111;
      end else if (proceed && in_valid_ff) begin
         phase_ff         <= phase_in;
         prefix_pos_ff    <= prefix_pos_in;
         topic_count_ff   <= topic_count_in;
         payload_count_ff <= payload_count_in;
         flags_ff         <= flags_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (proceed) begin
         out_valid_ff <= in_valid_ff && res.valid;
      end
      if (proceed) begin
         out_kind_ff  <= res.kind;
         out_char_ff  <= res.char_out;
         out_ok_ff    <= res.parse_ok;
         out_class_ff <= res.topic_class;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_kind        = out_kind_ff;
   assign rsp_char_out    = out_char_ff;
   assign rsp_parse_ok    = out_ok_ff;
   assign rsp_topic_class = out_class_ff;

   `MQRX_ASSERT_NOW(a_char_no_status, clock, reset,
      rsp_valid && (rsp_kind != mqrx_pkg::KIND_STATUS),
      !rsp_parse_ok && (rsp_topic_class == mqrx_pkg::CLASS_OTHER))
   `MQRX_ASSERT_NOW(a_fail_no_class, clock, reset,
      rsp_valid && (rsp_kind == mqrx_pkg::KIND_STATUS) && !rsp_parse_ok,
      (rsp_topic_class == mqrx_pkg::CLASS_OTHER) && (rsp_char_out == 8'h00))
   `MQRX_ASSERT_NEXT(a_eol_clears, clock, reset,
      proceed && in_valid_ff && in_eol_ff,
      (phase_ff == PH_PREFIX) && (topic_count_ff == '0) && (flags_ff == 3'b111)
         && rsp_valid && (rsp_kind == mqrx_pkg::KIND_STATUS))
   `MQRX_ASSERT_NOW(a_topic_bound, clock, reset,
      1'b1,
      (topic_count_ff <= TcW'(TOPIC_MAX - 1)) && (payload_count_ff <= PcW'(PAYLOAD_MAX - 1)))

endmodule
`default_nettype wire

[tb/mqtt_at_receive_line_parser_core_tb.sv]
// testbench for the subscription line parser: directed and random lines checked against a predictor
module mqtt_at_receive_line_parser_core_tb;
   import mqrx_pkg::*;

   typedef enum logic [3:0] {
      PH_LEAD, PH_SEEK_LINK, PH_TOPIC_OPEN, PH_TOPIC, PH_SKIP, PH_SEEK_LEN, PH_PAY_OPEN,
      PH_PAY, PH_DONE_OK, PH_DONE_BAD
   } parse_phase_e;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] chr;
      logic       ok;
      logic [1:0] cls;
   } line_result_t;

   typedef struct packed {
      logic [7:0] chr;
      logic       eol;
      logic       hold;
   } line_char_t;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_char_in = 8'h00;
   logic       req_end_of_line = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [1:0] rsp_kind;
   logic [7:0] rsp_char_out;
   logic       rsp_parse_ok;
   logic [1:0] rsp_topic_class;

   line_char_t   line_chars[$];
   line_result_t due_results[$];
   int           due_count = 0;
   int           mismatches = 0;
   int           cycle_no = 0;
   bit           hold_next = 1'b0;
   int           line_pos = 0;
   int           zero_at = -1;
   int           cut_at = 1 << 30;

   string lead_text = "AT+MQTTSUBRECV=";
   string topic_names[3] = '{"device/ota", "device/config", "device/cmd"};
   string topic_pool[12] = '{"device/ota", "device/config", "device/cmd", "device/ot",
                             "device/otax", "device/cmx", "device/conf", "Device/ota",
                             "device/config/", "", "device/cmdd", "devic"};

   parse_phase_e ph;
   logic [3:0]   lead_pos;
   logic [5:0]   topic_len;
   logic [9:0]   pay_len;
   logic [2:0]   class_hits;

   wire calm = cycle_no >= 600 && cycle_no < 1100;

   mqtt_at_receive_line_parser_core u_top (.*);

   always #1 clock = ~clock;

   function automatic void clear_line();
      ph = PH_LEAD;
      lead_pos = '0;
      topic_len = '0;
      pay_len = '0;
      class_hits = 3'b111;
   endfunction

   function automatic bit parse_char(input logic [7:0] c, input logic eol,
                                     output line_result_t r);
      bit ok;
      int k;
      r = '0;
      if (eol) begin
         ok = ph == PH_PAY_OPEN || ph == PH_DONE_OK;
         r.kind = KIND_STATUS;
         r.ok = ok;
         r.cls = CLASS_OTHER;
         if (ok) begin
            for (k = 2; k >= 0; k--)
               if (class_hits[k] && topic_len == topic_names[k].len()) r.cls = 2'(k + 1);
         end
         clear_line();
         return 1'b1;
      end
      if (ph == PH_DONE_OK || ph == PH_DONE_BAD) return 1'b0;
      if (c == CHAR_NUL) begin
         ph = ph == PH_PAY_OPEN ? PH_DONE_OK : PH_DONE_BAD;
         return 1'b0;
      end
      case (ph)
         PH_LEAD: begin
            if (lead_pos < PREFIX_LEN && c == lead_text[lead_pos]) begin
               lead_pos++;
               if (lead_pos == PREFIX_LEN) ph = PH_SEEK_LINK;
            end else begin
               ph = PH_DONE_BAD;
            end
         end
         PH_SEEK_LINK: if (c == CHAR_COMMA) ph = PH_TOPIC_OPEN;
         PH_TOPIC_OPEN: begin
            if (c == CHAR_QUOTE) ph = PH_TOPIC;
            else if (c == CHAR_COMMA) ph = PH_PAY_OPEN;
            else ph = PH_SEEK_LEN;
         end
         PH_TOPIC: begin
            if (c == CHAR_QUOTE) begin
               ph = PH_SKIP;
            end else if (topic_len < TopicMaxDefault - 1) begin
               for (k = 0; k < 3; k++)
                  if (topic_len >= topic_names[k].len() || c != topic_names[k][topic_len])
                     class_hits[k] = 1'b0;
               topic_len++;
               r.kind = KIND_TOPIC;
               r.chr = c;
               return 1'b1;
            end
         end
         PH_SKIP: ph = PH_SEEK_LEN;
         PH_SEEK_LEN: if (c == CHAR_COMMA) ph = PH_PAY_OPEN;
         PH_PAY_OPEN: ph = c == CHAR_QUOTE ? PH_PAY : PH_DONE_OK;
         PH_PAY: begin
            if (c == CHAR_QUOTE) begin
               ph = PH_DONE_OK;
            end else if (pay_len < PayloadMaxDefault - 1) begin
               pay_len++;
               r.kind = KIND_PAYLOAD;
               r.chr = c;
               return 1'b1;
            end
         end
         default: ph = PH_DONE_BAD;
      endcase
      return 1'b0;
   endfunction

   function automatic logic [7:0] any_but(input logic [7:0] x);
      logic [7:0] c;
      c = 8'($urandom_range(1, 254));
      if (c >= x) c++;
      return c;
   endfunction

   task automatic add_char(input logic [7:0] c);
      if (line_pos < cut_at) begin
         if (line_pos == zero_at) line_chars.push_back('{CHAR_NUL, 1'b0, 1'b0});
         line_chars.push_back('{c, 1'b0, hold_next});
         hold_next = 1'b0;
      end
      line_pos++;
   endtask

   task automatic add_text(input string s);
      foreach (s[i]) add_char(s[i]);
   endtask

   task automatic end_line();
      line_chars.push_back('{8'($urandom_range(0, 255)), 1'b1, hold_next});
      hold_next = 1'b0;
      line_pos = 0;
      zero_at = -1;
      cut_at = 1 << 30;
   endtask

   task automatic make_line(input bit long_pay);
      int  shape, n, p, i;
      bit  whole, via_comma;
      shape = long_pay ? 99 : $urandom_range(0, 99);
      hold_next = long_pay || $urandom_range(0, 99) < 4;
      if (!long_pay && $urandom_range(0, 99) < 8) zero_at = $urandom_range(0, 40);
      if (!long_pay && $urandom_range(0, 99) < 8) cut_at = $urandom_range(0, 40);
      if (shape < 8) begin
         repeat ($urandom_range(1, 20)) add_char(8'($urandom_range(0, 255)));
      end else if (shape < 14) begin
         n = $urandom_range(0, 14);
         for (i = 0; i < n; i++) add_char(lead_text[i]);
         add_char(any_but(lead_text[n]));
         repeat ($urandom_range(0, 4)) add_char(8'($urandom_range(1, 255)));
      end else begin
         add_text(lead_text);
         repeat ($urandom_range(0, 3)) add_char(any_but(CHAR_COMMA));
         whole = long_pay || $urandom_range(0, 99) >= 3;
         if (whole) begin
            add_char(CHAR_COMMA);
            n = long_pay ? 0 : $urandom_range(0, 99);
            via_comma = 1'b0;
            if (n < 65) begin
               add_char(CHAR_QUOTE);
               if (n < 45) add_text(topic_pool[$urandom_range(0, 11)]);
               else repeat ($urandom_range(0, 9) == 0 ? $urandom_range(55, 70) :
                            $urandom_range(0, 12)) add_char(any_but(CHAR_QUOTE));
               add_char(CHAR_QUOTE);
               add_char($urandom_range(0, 15) == 0 ? CHAR_NUL : 8'($urandom_range(1, 255)));
            end else if (n < 80) begin
               add_char(any_but(CHAR_QUOTE));
            end else if (n < 90) begin
               add_char(CHAR_COMMA);
               via_comma = 1'b1;
            end else begin
               add_char(CHAR_QUOTE);
               repeat ($urandom_range(0, 8)) add_char(any_but(CHAR_QUOTE));
               whole = 1'b0;
            end
            if (whole && !via_comma) begin
               repeat ($urandom_range(0, 3)) add_char(any_but(CHAR_COMMA));
               whole = long_pay || $urandom_range(0, 99) >= 3;
               if (whole) add_char(CHAR_COMMA);
            end
            if (whole) begin
               p = $urandom_range(0, 99);
               if (long_pay || p < 70) begin
                  add_char(CHAR_QUOTE);
                  repeat (long_pay ? 965 : $urandom_range(0, 20)) add_char(any_but(CHAR_QUOTE));
                  if (long_pay || p < 60) add_char(CHAR_QUOTE);
               end else if (p < 85) begin
                  add_char(any_but(CHAR_QUOTE));
               end
               if ($urandom_range(0, 99) < 30)
                  repeat ($urandom_range(1, 5)) add_char(8'($urandom_range(0, 255)));
            end
         end
      end
      end_line();
   endtask

   // request driver
   always @(posedge clock) begin
      bit took, go;
      took = req_valid && !req_stall;
      if (took) void'(line_chars.pop_front());
      if (!reset && !(req_valid && !took)) begin
         go = 1'b0;
         if (line_chars.size() != 0) begin
            if (line_chars[0].hold) go = !took && due_count == 0;
            else go = calm || $urandom_range(0, 99) >= 31;
         end
         req_valid <= go;
         if (go) begin
            req_char_in <= line_chars[0].chr;
            req_end_of_line <= line_chars[0].eol;
         end
      end
   end

   always @(posedge clock) begin
      cycle_no <= cycle_no + 1;
      rsp_stall <= !reset && !calm && $urandom_range(0, 99) < 31;
   end

   // result checker and request predictor
   always @(posedge clock) begin
      line_result_t want, got;
      if (reset) begin
         clear_line();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (due_results.size() == 0) begin
               $error("result with nothing due: kind %0d char %0h", rsp_kind, rsp_char_out);
               mismatches++;
            end else begin
               want = due_results.pop_front();
               if (rsp_kind !== want.kind) begin
                  $error("kind: expected %0d, got %0d", want.kind, rsp_kind);
                  mismatches++;
               end
               if (rsp_char_out !== want.chr) begin
                  $error("char_out: expected %0h, got %0h", want.chr, rsp_char_out);
                  mismatches++;
               end
               if (rsp_parse_ok !== want.ok) begin
                  $error("parse_ok: expected %0d, got %0d", want.ok, rsp_parse_ok);
                  mismatches++;
               end
               if (rsp_topic_class !== want.cls) begin
                  $error("topic_class: expected %0d, got %0d", want.cls, rsp_topic_class);
                  mismatches++;
               end
            end
         end
         if (req_valid && !req_stall && parse_char(req_char_in, req_end_of_line, got))
            due_results.push_back(got);
      end
      due_count <= due_results.size();
   end

   initial begin
      int lines;
      end_line();
      add_char("A");
      add_char(8'hff);
      add_char("T");
      end_line();
      add_char(CHAR_NUL);
      add_char("A");
      end_line();
      add_text(lead_text);
      add_char(CHAR_COMMA);
      add_char(CHAR_COMMA);
      end_line();
      for (lines = 0; line_chars.size() < 1250; lines++) make_line(lines == 3);

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      do @(negedge clock);
      while (line_chars.size() != 0 || req_valid || due_count != 0);
      repeat (20) @(negedge clock);
      if (mismatches == 0 && due_results.size() == 0)
         $display("PASS mqtt_at_receive_line_parser_core");
      else
         $display("FAIL mqtt_at_receive_line_parser_core");
      $finish;
   end

   initial begin
      #2000000;
      $display("FAIL mqtt_at_receive_line_parser_core");
      $finish;
   end

endmodule

[mqtt_at_receive_line_parser_core.f]
+incdir+src
src/mqrx_pkg.sv
src/mqtt_at_receive_line_parser_core.sv
tb/mqtt_at_receive_line_parser_core_tb.sv
